// ===== src/instruction_trace_compressor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the instruction trace compressor
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_TRACE_COMPRESSOR_ASSERT_SVH
`define INSTRUCTION_TRACE_COMPRESSOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/itc_pkg.sv =====
// ----------------------------------------------------------------------------
// itc_pkg
// Types, codes and defaults shared by the instruction trace compressor.
// ----------------------------------------------------------------------------
package itc_pkg;

	localparam int MAP_DEPTH_DEF   = 31;
	localparam int ADDR_BITS_DEF   = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int WORD_W  = 32;
	localparam int PRIV_W  = 5;
	localparam int CAUSE_W = 5;
	localparam int CNT_W   = 5;
	localparam int BITS_W  = 31;

	// Address steps that count as sequential flow.
	localparam logic [2:0] STEP_FULL       = 3'd4;
	localparam logic [2:0] STEP_COMPRESSED = 3'd2;

	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [2:0] F3_JALR    = 3'd0;
	localparam logic [2:0] F3_RSV_A   = 3'd2;
	localparam logic [2:0] F3_RSV_B   = 3'd3;

	typedef enum logic [1:0] {
		FMT_BRANCH_MAP  = 2'd0,
		FMT_BRANCH_DIFF = 2'd1,
		FMT_ADDR_ONLY   = 2'd2,
		FMT_SYNC        = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		SYNC_START     = 2'd0,
		SYNC_EXCEPTION = 2'd1,
		SYNC_CONTEXT   = 2'd2
	} sync_t;

	typedef struct packed {
		logic [WORD_W-1:0]  instr_word;
		logic [WORD_W-1:0]  instr_addr;
		logic [PRIV_W-1:0]  privilege;
		logic               is_exception;
		logic               is_interrupt;
		logic [CAUSE_W-1:0] trap_cause;
		logic [WORD_W-1:0]  trap_value;
		logic               next_present;
		logic [WORD_W-1:0]  next_addr;
		logic               next_exception;
		logic [PRIV_W-1:0]  next_privilege;
	} instr_t;

	typedef struct packed {
		fmt_t               packet_format;
		sync_t              sync_subformat;
		logic [PRIV_W-1:0]  packet_privilege;
		logic [CNT_W-1:0]   branch_count;
		logic [BITS_W-1:0]  branch_bits;
		logic               has_address;
		logic [WORD_W-1:0]  packet_address;
		logic [CAUSE_W-1:0] exc_cause;
		logic               exc_interrupt;
		logic [WORD_W-1:0]  exc_value;
	} pkt_t;

	// Classified instruction as it travels from the front to the back.
	typedef struct packed {
		logic [WORD_W-1:0]  addr;
		logic [PRIV_W-1:0]  privilege;
		logic               exception;
		logic               interrupt;
		logic [CAUSE_W-1:0] cause;
		logic [WORD_W-1:0]  tval;
		logic               cond_branch;
		logic               jalr;
		logic               taken;
		logic               next_exc;
		logic               next_priv_change;
	} entry_t;

	function automatic logic is_cond_branch(input logic [WORD_W-1:0] w);
		logic [2:0] f3;
		f3 = w[14:12];
		return (w[6:0] == OPC_BRANCH) && (f3 != F3_RSV_A) && (f3 != F3_RSV_B);
	endfunction

	function automatic logic is_jalr(input logic [WORD_W-1:0] w);
		return (w[6:0] == OPC_JALR) && (w[14:12] == F3_JALR);
	endfunction

endpackage

// ===== src/itc_if.sv =====
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for retired instructions and trace packets.
// ----------------------------------------------------------------------------
interface itc_instr_if;
	logic            valid;
	logic            ready;
	itc_pkg::instr_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface itc_pkt_if;
	logic          valid;
	logic          ready;
	itc_pkg::pkt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/itc_front.sv =====
// ----------------------------------------------------------------------------
// itc_front
// Accepts retired instructions and classifies them for the back end.
// ----------------------------------------------------------------------------
module itc_front #(
	parameter int ADDR_BITS = itc_pkg::ADDR_BITS_DEF
) (
	itc_instr_if.sink        instr,
	input  logic             q_full,
	output logic             push,
	output itc_pkg::entry_t  entry
);

	logic [ADDR_BITS-1:0] addr_ext;
	logic [ADDR_BITS-1:0] next_ext;
	logic                 sequential;

	assign instr.ready = !q_full;
	assign push        = instr.valid && !q_full;

	// The sequential check wraps at the configured address width.
	always_comb begin
		addr_ext   = ADDR_BITS'(instr.data.instr_addr);
		next_ext   = ADDR_BITS'(instr.data.next_addr);
		sequential = ((addr_ext + ADDR_BITS'(itc_pkg::STEP_FULL)) == next_ext) ||
			((addr_ext + ADDR_BITS'(itc_pkg::STEP_COMPRESSED)) == next_ext);

		entry.addr        = instr.data.instr_addr;
		entry.privilege   = instr.data.privilege;
		entry.exception   = instr.data.is_exception;
		entry.interrupt   = instr.data.is_interrupt;
		entry.cause       = instr.data.trap_cause;
		entry.tval        = instr.data.trap_value;
		entry.cond_branch = itc_pkg::is_cond_branch(instr.data.instr_word);
		entry.jalr        = itc_pkg::is_jalr(instr.data.instr_word);
		entry.taken       = instr.data.next_present && !sequential;
		// Without a lookahead the next instruction is assumed to trap like this one.
		entry.next_exc    = instr.data.next_present ? instr.data.next_exception
			: instr.data.is_exception;
		entry.next_priv_change = instr.data.next_present &&
			(instr.data.next_privilege != instr.data.privilege);
	end

endmodule

// ===== src/itc_queue.sv =====
// ----------------------------------------------------------------------------
// itc_queue
// Short FIFO of classified instructions between the front and the back end.
// ----------------------------------------------------------------------------
module itc_queue #(
	parameter int DEPTH = itc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  itc_pkg::entry_t            push_data,
	input  logic                       pop,
	output itc_pkg::entry_t            pop_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	itc_pkg::entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == ($clog2(DEPTH+1))'(DEPTH));
	assign count    = count_q;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/itc_back.sv =====
// ----------------------------------------------------------------------------
// itc_back
// Keeps the branch map and resync state and forms at most one packet per instruction.
// ----------------------------------------------------------------------------
module itc_back #(
	parameter int MAP_DEPTH = itc_pkg::MAP_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [itc_pkg::WORD_W-1:0]   cfg_data,
	input  logic                         q_valid,
	input  itc_pkg::entry_t              q_entry,
	output logic                         q_pop,
	itc_pkt_if.source                    packet
);

	localparam logic [itc_pkg::CNT_W-1:0] MAP_LIMIT = itc_pkg::CNT_W'(MAP_DEPTH);

	logic [itc_pkg::WORD_W-1:0]  resync_period_q;
	logic [itc_pkg::WORD_W-1:0]  resync_count_q;
	logic                        resync_pending_q;
	logic                        seen_first_q;
	logic                        prev_exception_q;
	logic                        prev_jalr_q;
	logic [itc_pkg::PRIV_W-1:0]  prev_privilege_q;
	logic [itc_pkg::CAUSE_W-1:0] prev_cause_q;
	logic                        prev_interrupt_q;
	logic [itc_pkg::WORD_W-1:0]  prev_tval_q;
	logic [MAP_DEPTH-1:0]        map_bits_q;
	logic [itc_pkg::CNT_W-1:0]   map_count_q;
	logic                        map_full_q;
	logic                        out_valid_q;
	itc_pkg::pkt_t               out_pkt_q;

	logic                        advance;
	logic                        hit;
	logic                        pend;
	logic                        pend_n;
	logic [itc_pkg::WORD_W-1:0]  resync_count_n;
	logic                        record;
	logic [MAP_DEPTH-1:0]        set_vec;
	logic [MAP_DEPTH-1:0]        bits_n;
	logic [itc_pkg::CNT_W-1:0]   count_n;
	logic                        full_n;
	logic                        emit;
	logic                        with_map;
	itc_pkg::pkt_t               pkt_n;

	assign advance      = q_valid && (!out_valid_q || packet.ready);
	assign q_pop        = advance;
	assign packet.valid = out_valid_q;
	assign packet.data  = out_pkt_q;

	always_comb begin
		hit            = (resync_count_q == resync_period_q);
		pend           = resync_pending_q || hit;
		resync_count_n = hit ? '0 : resync_count_q + 1'b1;

		// A branch beyond a full, unflushed map is dropped.
		record = q_entry.cond_branch && (map_count_q < MAP_LIMIT);
		for (int i = 0; i < MAP_DEPTH; i++) begin
			set_vec[i] = record && q_entry.taken &&
				(map_count_q == itc_pkg::CNT_W'(i));
		end
		bits_n  = map_bits_q | set_vec;
		count_n = map_count_q + itc_pkg::CNT_W'(record);
		full_n  = map_full_q || (record && (count_n == MAP_LIMIT));

		pkt_n    = '0;
		emit     = 1'b1;
		with_map = 1'b0;
		pend_n   = pend;

		if (prev_exception_q) begin
			pkt_n.packet_format    = itc_pkg::FMT_SYNC;
			pkt_n.sync_subformat   = itc_pkg::SYNC_EXCEPTION;
			pkt_n.packet_privilege = q_entry.privilege;
			pkt_n.has_address      = 1'b1;
			pkt_n.packet_address   = q_entry.addr;
			pkt_n.exc_cause        = prev_cause_q;
			pkt_n.exc_interrupt    = prev_interrupt_q;
			pkt_n.exc_value        = prev_tval_q;
			pend_n                 = 1'b0;
		end else if (!seen_first_q || (q_entry.privilege != prev_privilege_q) ||
			(pend && (count_n == '0))) begin
			pkt_n.packet_format    = itc_pkg::FMT_SYNC;
			pkt_n.sync_subformat   = itc_pkg::SYNC_START;
			pkt_n.packet_privilege = q_entry.privilege;
			pkt_n.has_address      = 1'b1;
			pkt_n.packet_address   = q_entry.addr;
			pend_n                 = 1'b0;
		end else if (prev_jalr_q || pend || q_entry.next_exc ||
			q_entry.next_priv_change) begin
			// A pending resync reaching here always has a non-empty map.
			if (count_n == '0) begin
				pkt_n.packet_format = itc_pkg::FMT_ADDR_ONLY;
			end else begin
				pkt_n.packet_format = itc_pkg::FMT_BRANCH_MAP;
				with_map            = 1'b1;
			end
			pkt_n.has_address    = 1'b1;
			pkt_n.packet_address = q_entry.addr;
		end else if (full_n) begin
			pkt_n.packet_format = itc_pkg::FMT_BRANCH_MAP;
			with_map            = 1'b1;
		end else begin
			emit = 1'b0;
		end

		if (with_map) begin
			pkt_n.branch_count = count_n;
			pkt_n.branch_bits  = itc_pkg::BITS_W'(bits_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resync_period_q  <= '1;
			resync_count_q   <= '0;
			resync_pending_q <= 1'b0;
			seen_first_q     <= 1'b0;
			prev_exception_q <= 1'b0;
			prev_jalr_q      <= 1'b0;
			prev_privilege_q <= '0;
			prev_cause_q     <= '0;
			prev_interrupt_q <= 1'b0;
			prev_tval_q      <= '0;
			map_bits_q       <= '0;
			map_count_q      <= '0;
			map_full_q       <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				resync_period_q <= cfg_data;
			end
			if (advance) begin
				resync_count_q   <= resync_count_n;
				resync_pending_q <= pend_n;
				seen_first_q     <= 1'b1;
				prev_exception_q <= q_entry.exception;
				prev_jalr_q      <= q_entry.jalr;
				prev_privilege_q <= q_entry.privilege;
				prev_cause_q     <= q_entry.cause;
				prev_interrupt_q <= q_entry.interrupt;
				prev_tval_q      <= q_entry.tval;
				map_bits_q       <= with_map ? '0 : bits_n;
				map_count_q      <= with_map ? '0 : count_n;
				map_full_q       <= with_map ? 1'b0 : full_n;
				out_valid_q      <= emit;
			end else if (packet.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_pkt_q <= pkt_n;
		end
	end

endmodule

// ===== src/instruction_trace_compressor.sv =====
// ----------------------------------------------------------------------------
// instruction_trace_compressor
// Branch-trace encoder for a stream of retired RV32 instructions.
// ----------------------------------------------------------------------------
// The instr channel takes one retired instruction per transaction, along with
// a lookahead of the instruction that follows it. The packet channel returns
// at most one trace packet per instruction: sync, address-only or branch map.
// The user must write the resync period through cfg_we/cfg_data only while the
// block is idle; the block itself does not enforce this.
// An accepted instruction is written into the queue, and any packet for it is
// then formed in the back end's output register. One instruction is taken per
// cycle while the packet receiver does not stall; the back end updates the branch
// map and resync state for one instruction per cycle from a two-entry queue.
//
// Reset clears the map, the resync counter and the history of the previous
// instruction, and sets the resync period to its maximum. When the packet
// receiver stalls, the back end holds its output register, the queue fills
// and instr.ready drops once the queue is full; no packet is lost.
// ----------------------------------------------------------------------------
`include "instruction_trace_compressor_assert.svh"

module instruction_trace_compressor #(
	parameter int MAP_DEPTH   = itc_pkg::MAP_DEPTH_DEF,
	parameter int ADDR_BITS   = itc_pkg::ADDR_BITS_DEF,
	parameter int QUEUE_DEPTH = itc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [itc_pkg::WORD_W-1:0] cfg_data,
	itc_instr_if.sink                  instr,
	itc_pkt_if.source                  packet
);

	logic                             push;
	itc_pkg::entry_t                  push_data;
	logic                             pop;
	itc_pkg::entry_t                  pop_data;
	logic                             q_empty;
	logic                             q_full;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	itc_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.instr (instr),
		.q_full(q_full),
		.push  (push),
		.entry (push_data)
	);

	itc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty),
		.full     (q_full),
		.count    (q_count)
	);

	itc_back #(
		.MAP_DEPTH(MAP_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.q_valid (!q_empty),
		.q_entry (pop_data),
		.q_pop   (pop),
		.packet  (packet)
	);

	`ITC_ASSERT_IMP(a_queue_bound, 1'b1, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue occupancy beyond its depth")
	`ITC_ASSERT_NXT(a_push_counts, push && !pop, q_count == $past(q_count) + 1'b1, "queue count missed a push")
	`ITC_ASSERT_IMP(a_full_map, packet.valid && (packet.data.packet_format == itc_pkg::FMT_BRANCH_MAP) && !packet.data.has_address, packet.data.branch_count == itc_pkg::CNT_W'(MAP_DEPTH), "map packet without address from a partial map")
	`ITC_ASSERT_IMP(a_exc_fields, packet.valid && (packet.data.sync_subformat != itc_pkg::SYNC_EXCEPTION), (packet.data.exc_cause == '0) && (packet.data.exc_value == '0) && !packet.data.exc_interrupt, "trap data outside a sync-exception packet")

endmodule

// ===== test/itc_packet_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itc_packet_checker
// Watches both channels of the instruction trace compressor, predicts the
// trace packet, if any, each accepted instruction should produce and compares
// every accepted packet, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module itc_packet_checker
	import itc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_data,
	itc_instr_if              instr,
	itc_pkt_if                packet,
	output int                errors,
	output int                outstanding,
	output int                checked
);

	localparam int MAP_DEPTH = MAP_DEPTH_DEF;

	// Shadow copy of the encoder state.
	logic [WORD_W-1:0]  resync_period_r;
	logic [WORD_W-1:0]  resync_tally;
	logic               resync_req;
	logic [BITS_W-1:0]  map_bits_r;
	logic [CNT_W-1:0]   map_cnt;
	logic               map_is_full;
	logic               seen_any;
	logic               last_exc;
	logic               last_jalr;
	logic [PRIV_W-1:0]  last_priv;
	logic [CAUSE_W-1:0] last_cause;
	logic               last_intr;
	logic [WORD_W-1:0]  last_tval;

	pkt_t expected_pkts[$];
	int   err_total;
	int   pkt_total;

	task automatic predict_packet(input instr_t it, output bit emit, output pkt_t p);
		logic              next_trap;
		logic              priv_moves;
		logic              seq_flow;
		logic              flush_map;
		logic              cond_branch;
		logic [6:0]        opc;
		logic [2:0]        f3;
		logic [WORD_W-1:0] step4;
		logic [WORD_W-1:0] step2;
		opc = it.instr_word[6:0];
		f3 = it.instr_word[14:12];
		cond_branch = (opc == OPC_BRANCH) && (f3 != F3_RSV_A) && (f3 != F3_RSV_B);
		// Without a lookahead the trap status of this instruction stands in for the next.
		next_trap = it.next_present ? it.next_exception : it.is_exception;
		priv_moves = it.next_present && (it.next_privilege != it.privilege);
		p = '0;
		emit = 1'b1;
		flush_map = 1'b0;

		if (resync_tally == resync_period_r) begin
			resync_req = 1'b1;
			resync_tally = '0;
		end else begin
			resync_tally = resync_tally + 1'b1;
		end

		// A branch arriving while the map is full is dropped.
		if (cond_branch && map_cnt < MAP_DEPTH) begin
			step4 = it.instr_addr + STEP_FULL;
			step2 = it.instr_addr + STEP_COMPRESSED;
			seq_flow = (step4 == it.next_addr) || (step2 == it.next_addr);
			if (it.next_present && !seq_flow)
				map_bits_r[map_cnt] = 1'b1;
			map_cnt = map_cnt + 1'b1;
			if (map_cnt == MAP_DEPTH)
				map_is_full = 1'b1;
		end

		if (last_exc) begin
			p.packet_format = FMT_SYNC;
			p.sync_subformat = SYNC_EXCEPTION;
			p.packet_privilege = it.privilege;
			p.has_address = 1'b1;
			p.packet_address = it.instr_addr;
			p.exc_cause = last_cause;
			p.exc_interrupt = last_intr;
			p.exc_value = last_tval;
			resync_req = 1'b0;
		end else if (!seen_any || it.privilege != last_priv || (resync_req && map_cnt == 0)) begin
			p.packet_format = FMT_SYNC;
			p.sync_subformat = SYNC_START;
			p.packet_privilege = it.privilege;
			p.has_address = 1'b1;
			p.packet_address = it.instr_addr;
			resync_req = 1'b0;
		end else if (last_jalr || resync_req || next_trap || priv_moves) begin
			// A pending resync with an empty map was taken by the branch above.
			if (map_cnt == 0) begin
				p.packet_format = FMT_ADDR_ONLY;
			end else begin
				p.packet_format = FMT_BRANCH_MAP;
				flush_map = 1'b1;
			end
			p.has_address = 1'b1;
			p.packet_address = it.instr_addr;
		end else if (map_is_full) begin
			p.packet_format = FMT_BRANCH_MAP;
			flush_map = 1'b1;
		end else begin
			emit = 1'b0;
		end

		if (flush_map) begin
			p.branch_count = map_cnt;
			p.branch_bits = map_bits_r;
			map_bits_r = '0;
			map_cnt = '0;
			map_is_full = 1'b0;
		end

		last_exc = it.is_exception;
		last_jalr = (opc == OPC_JALR) && (f3 == F3_JALR);
		last_priv = it.privilege;
		last_cause = it.trap_cause;
		last_intr = it.is_interrupt;
		last_tval = it.trap_value;
		seen_any = 1'b1;
	endtask

	function automatic void flag_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: packet %0d, %s mismatch: expected %0h, actual %0h",
				$time, pkt_total, name, want, got);
			err_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit   emit;
		pkt_t want;
		pkt_t got;
		if (!arst_n) begin
			resync_period_r = '1;
			resync_tally = '0;
			resync_req = 1'b0;
			map_bits_r = '0;
			map_cnt = '0;
			map_is_full = 1'b0;
			seen_any = 1'b0;
			last_exc = 1'b0;
			last_jalr = 1'b0;
			last_priv = '0;
			last_cause = '0;
			last_intr = 1'b0;
			last_tval = '0;
			expected_pkts.delete();
			err_total = 0;
			pkt_total = 0;
		end else begin
			if (cfg_we)
				resync_period_r = cfg_data;

			// A packet never belongs to the instruction taken at the same edge.
			if (packet.valid === 1'b1 && packet.ready === 1'b1) begin
				got = packet.data;
				if (expected_pkts.size() == 0) begin
					$display("%0t: unexpected packet, expected none, actual %0h", $time, got);
					err_total++;
				end else begin
					want = expected_pkts.pop_front();
					flag_field("packet_format", want.packet_format, got.packet_format);
					flag_field("sync_subformat", want.sync_subformat, got.sync_subformat);
					flag_field("packet_privilege", want.packet_privilege, got.packet_privilege);
					flag_field("branch_count", want.branch_count, got.branch_count);
					flag_field("branch_bits", want.branch_bits, got.branch_bits);
					flag_field("has_address", want.has_address, got.has_address);
					flag_field("packet_address", want.packet_address, got.packet_address);
					flag_field("exc_cause", want.exc_cause, got.exc_cause);
					flag_field("exc_interrupt", want.exc_interrupt, got.exc_interrupt);
					flag_field("exc_value", want.exc_value, got.exc_value);
				end
				pkt_total++;
			end

			if (instr.valid === 1'b1 && instr.ready === 1'b1) begin
				predict_packet(instr.data, emit, want);
				if (emit)
					expected_pkts.push_back(want);
			end
		end
		errors <= err_total;
		outstanding <= expected_pkts.size();
		checked <= pkt_total;
	end

endmodule

// ===== test/tb_instruction_trace_compressor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_instruction_trace_compressor
// Drives the trace compressor with directed corner cases and then with
// random instruction traces under several resync periods, with random gaps
// on both channels; a separate checker predicts and compares every packet.
// ----------------------------------------------------------------------------
module tb_instruction_trace_compressor;
	import itc_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_WAIT     = 12;
	localparam int SETTLE       = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int NOISE_PCT    = 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [WORD_W-1:0] cfg_data;

	itc_instr_if instr_ch();
	itc_pkt_if   pkt_ch();

	int errors;
	int outstanding;
	int checked;
	int sent;
	int settings;
	int cycles;

	// Trace generator state: the lookahead of one item becomes the next item.
	logic [WORD_W-1:0] gen_pc;
	logic [PRIV_W-1:0] gen_priv;
	logic              gen_exc;
	int                jalr_pct;
	int                exc_pct;
	int                priv_pct;
	bit                tx_steady;

	always #10 clk = ~clk;

	instruction_trace_compressor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.instr    (instr_ch),
		.packet   (pkt_ch)
	);

	itc_packet_checker pkt_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.instr       (instr_ch),
		.packet      (pkt_ch),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Packet receiver: random stall before each transaction, with steady stretches.
	initial begin : receiver
		int stall;
		bit rx_steady;
		pkt_ch.ready = 1'b0;
		rx_steady = 1'b0;
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
			repeat (stall) begin
				@(negedge clk);
				pkt_ch.ready <= 1'b0;
			end
			@(negedge clk);
			pkt_ch.ready <= 1'b1;
			do @(posedge clk); while (!(pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1));
		end
	end

	task automatic send_instr(input instr_t it);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
		repeat (gap) begin
			@(negedge clk);
			instr_ch.valid <= 1'b0;
		end
		@(negedge clk);
		instr_ch.valid <= 1'b1;
		instr_ch.data <= it;
		do @(posedge clk); while (instr_ch.ready !== 1'b1);
		sent++;
	endtask

	task automatic send_basic(input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] addr,
			input int priv, input int exc, input int npres,
			input logic [WORD_W-1:0] naddr, input int nexc, input int npriv);
		instr_t it;
		it.instr_word = word;
		it.instr_addr = addr;
		it.privilege = PRIV_W'(priv);
		it.is_exception = (exc != 0);
		it.is_interrupt = (exc != 0);
		it.trap_cause = (exc != 0) ? '1 : '0;
		it.trap_value = (exc != 0) ? '1 : '0;
		it.next_present = (npres != 0);
		it.next_addr = naddr;
		it.next_exception = (nexc != 0);
		it.next_privilege = PRIV_W'(npriv);
		send_instr(it);
	endtask

	task automatic new_trace();
		gen_pc = $urandom;
		gen_pc[0] = 1'b0;
		// Some traces start just below the top of the address space.
		if ($urandom_range(0, 7) == 0)
			gen_pc[WORD_W-1:8] = '1;
		gen_priv = PRIV_W'($urandom);
		gen_exc = 1'b0;
	endtask

	task automatic make_item(output instr_t it);
		int                roll;
		bit                branch;
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] nxt;
		it = '0;
		it.instr_addr = gen_pc;
		it.privilege = gen_priv;
		it.is_exception = gen_exc;
		it.is_interrupt = 1'($urandom);
		it.trap_cause = CAUSE_W'($urandom);
		it.trap_value = $urandom;
		roll = $urandom_range(0, 99);
		branch = 1'b0;
		w = $urandom;
		if (roll < 50) begin
			w[6:0] = OPC_BRANCH;
			branch = 1'b1;
		end else if (roll < 50 + jalr_pct) begin
			w[6:0] = OPC_JALR;
			w[14:12] = F3_JALR;
		end else if (roll < 52 + jalr_pct) begin
			w[6:0] = OPC_JALR;
		end
		it.instr_word = w;

		if ((branch || w[6:0] == OPC_JALR) && $urandom_range(0, 1)) begin
			nxt = $urandom;
			nxt[0] = 1'b0;
		end else begin
			nxt = gen_pc + (($urandom_range(0, 3) == 0) ? 32'd2 : 32'd4);
		end
		it.next_addr = nxt;
		it.next_exception = ($urandom_range(0, 99) < exc_pct);
		it.next_privilege = ($urandom_range(0, 99) < priv_pct) ? PRIV_W'($urandom) : gen_priv;
		it.next_present = ($urandom_range(0, 99) >= 2);

		if (!it.next_present) begin
			it.next_addr = $urandom;
			it.next_exception = 1'($urandom);
			it.next_privilege = PRIV_W'($urandom);
			new_trace();
		end else begin
			gen_pc = nxt;
			gen_priv = it.next_privilege;
			gen_exc = it.next_exception;
		end

		if ($urandom_range(0, 99) < NOISE_PCT) begin
			it.instr_word = $urandom;
			it.instr_addr = $urandom;
			it.privilege = PRIV_W'($urandom);
			it.is_exception = 1'($urandom);
			it.next_present = 1'($urandom);
			it.next_addr = $urandom;
			it.next_exception = 1'($urandom);
			it.next_privilege = PRIV_W'($urandom);
		end
	endtask

	// Waits until every predicted packet has arrived and the pipeline has drained.
	task automatic wait_idle();
		@(negedge clk);
		instr_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(input logic [WORD_W-1:0] period, input bit write_it);
		instr_t it;
		if (write_it) begin
			wait_idle();
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_data <= period;
			@(negedge clk);
			cfg_we <= 1'b0;
		end
		settings++;
		jalr_pct = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
		exc_pct = $urandom_range(0, 4);
		priv_pct = $urandom_range(0, 4);
		new_trace();
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i % 40 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			make_item(it);
			send_instr(it);
		end
	endtask

	initial begin
		logic [WORD_W-1:0] rand_period;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		instr_ch.valid = 1'b0;
		instr_ch.data = '0;
		tx_steady = 1'b0;
		sent = 0;
		settings = 0;
		cycles = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed corner cases under the reset resync period.
		send_basic(32'h0000_0013, 32'h0000_0000, 0, 0, 1, 32'h0000_0004, 0, 0);
		send_basic(32'h0000_0063, 32'h0000_0004, 0, 0, 1, 32'h0000_0008, 0, 0);
		send_basic(32'hFFFF_FFE3, 32'h0000_0008, 0, 0, 1, 32'h0000_0100, 0, 0);
		send_basic(32'h0000_2063, 32'h0000_0100, 0, 0, 1, 32'h0000_0104, 0, 0);
		send_basic(32'h0000_3063, 32'h0000_0104, 0, 0, 1, 32'h0000_0108, 0, 0);
		send_basic(32'h0000_1063, 32'h0000_0108, 0, 0, 1, 32'h0000_010A, 0, 0);
		send_basic(32'h0000_4063, 32'h0000_010A, 0, 0, 0, 32'h0000_0777, 1, 5);
		send_basic(32'h0000_8067, 32'h0000_010E, 0, 0, 1, 32'h0000_0200, 0, 0);
		send_basic(32'h0000_8067, 32'h0000_0200, 0, 0, 1, 32'h0000_0300, 0, 0);
		send_basic(32'h0000_0013, 32'h0000_0300, 0, 0, 1, 32'h0000_0304, 0, 0);
		send_basic(32'h0000_9067, 32'h0000_0304, 0, 0, 1, 32'h0000_0308, 0, 0);
		send_basic(32'h0000_5063, 32'h0000_0308, 0, 0, 1, 32'h0000_030C, 0, 0);
		send_basic(32'h0000_6063, 32'h0000_030C, 0, 0, 1, 32'h0000_0400, 1, 0);
		send_basic(32'h0000_0073, 32'h0000_0400, 0, 1, 1, 32'h0000_0000, 0, 31);
		send_basic(32'h0000_0013, 32'h0000_0000, 31, 0, 1, 32'h0000_0004, 0, 31);
		send_basic(32'hFFFF_FFFF, 32'h0000_0004, 31, 0, 1, 32'h0000_0008, 0, 0);
		send_basic(32'h0000_0013, 32'h0000_0008, 0, 0, 1, 32'hFFFF_FFFC, 0, 0);
		// Sequential flow across the top of the address space.
		send_basic(32'h0000_0063, 32'hFFFF_FFFC, 0, 0, 1, 32'h0000_0000, 0, 0);
		send_basic(32'h0000_0063, 32'hFFFF_FFFE, 0, 0, 1, 32'h0000_0000, 0, 0);
		send_basic(32'h0000_0063, 32'hFFFF_FFFC, 0, 0, 1, 32'hFFFF_FFFE, 0, 0);
		send_basic(32'h0000_0063, 32'hFFFF_FFFE, 0, 0, 1, 32'h1234_5678, 0, 0);
		// A trap at the end of the trace flushes the map with an address.
		send_basic(32'h0000_0013, 32'h1234_5678, 0, 1, 0, 32'h0000_0000, 0, 0);
		send_basic(32'h0000_0013, 32'h0000_0000, 0, 0, 1, 32'h0000_0004, 0, 0);

		run_phase('1, 1'b0);
		run_phase(32'd0, 1'b1);
		run_phase(32'd1, 1'b1);
		run_phase(32'd2, 1'b1);
		run_phase(32'd7, 1'b1);
		run_phase(32'd40, 1'b1);
		rand_period = $urandom_range(3, 200);
		run_phase(rand_period, 1'b1);
		rand_period = $urandom;
		run_phase(rand_period, 1'b1);
		run_phase(32'hFFFF_FFFF, 1'b1);

		wait_idle();
		$display("Summary: %0d instructions (directed corner cases, then random traces)",
			sent);
		$display("Summary: %0d resync settings used, %0d packets compared", settings, checked);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches found", errors);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/itc_pkg.sv
src/itc_if.sv
src/itc_front.sv
src/itc_queue.sv
src/itc_back.sv
src/instruction_trace_compressor.sv
test/itc_packet_checker.sv
test/tb_instruction_trace_compressor.sv
